[hw/rtl/mtmkr_pkg.sv]
`timescale 1ns / 1ps

package mtmkr_pkg;

  localparam int TABLE_DEPTH   = 32;
  localparam int KEY_BITS      = 10;
  localparam int SLOT_BITS     = 5;
  localparam int TIME_BITS     = 32;
  localparam int TAP_BITS      = 3;
  localparam int RES_BITS      = 2;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 32;

  localparam int ADDR_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int VALID_N    = 1 << ADDR_W;
  localparam int SLOT_EXT_W = (SLOT_BITS > CNT_W) ? SLOT_BITS : CNT_W;

  // input beat layout
  localparam int OFS_SCAN    = 0;
  localparam int OFS_KEY     = OFS_SCAN + KEY_BITS;
  localparam int OFS_PRESS   = OFS_KEY + KEY_BITS;
  localparam int OFS_TIME    = OFS_PRESS + 1;
  localparam int OFS_SLOT    = OFS_TIME + TIME_BITS;
  localparam int OFS_TARGET  = OFS_SLOT + SLOT_BITS;
  localparam int OFS_SHIFT   = OFS_TARGET + KEY_BITS;
  localparam int IN_USED     = OFS_SHIFT + 1;
  localparam int IN_TDATA_W  = ((IN_USED + 7) / 8) * 8;

  // output beat layout
  localparam int OFS_OKEY    = 0;
  localparam int OFS_OSHIFT  = OFS_OKEY + KEY_BITS;
  localparam int OFS_OTAP    = OFS_OSHIFT + 1;
  localparam int OUT_USED    = OFS_OTAP + TAP_BITS;
  localparam int OUT_TDATA_W = ((OUT_USED + 7) / 8) * 8;

  localparam logic [RES_BITS-1:0] RES_CONSUMED = 2'd0;
  localparam logic [RES_BITS-1:0] RES_UNMAPPED = 2'd1;
  localparam logic [RES_BITS-1:0] RES_MAPPED   = 2'd2;
  localparam logic [RES_BITS-1:0] RES_WRITTEN  = 2'd3;

  localparam logic [TAP_BITS-1:0] TAP_IDLE        = 3'd0;
  localparam logic [TAP_BITS-1:0] TAP_SINGLE      = 3'd1;
  localparam logic [TAP_BITS-1:0] TAP_DOUBLE      = 3'd2;
  localparam logic [TAP_BITS-1:0] TAP_HELD        = 3'd3;
  localparam logic [TAP_BITS-1:0] TAP_HELD_CLICK  = 3'd4;
  localparam logic [TAP_BITS-1:0] TAP_HELD_DOUBLE = 3'd5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODIFIER = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_GAP  = 1'd1;

  localparam logic [KEY_BITS-1:0]  MODIFIER_RESET = KEY_BITS'(57);
  localparam logic [TIME_BITS-1:0] TAP_GAP_RESET  = TIME_BITS'(1000000);

  typedef struct packed {
    logic                shift;
    logic [KEY_BITS-1:0] target;
    logic [KEY_BITS-1:0] source;
  } entry_t;

  typedef struct packed {
    logic                accept;
    logic [RES_BITS-1:0] res_code;
    logic                mod_edge;
    logic                scan_run;
    logic                take_hit;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic req_write;
    logic is_mod;
    logic lookup_en;
    logic hit;
    logic miss;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/mtmkr_ram.sv]
`timescale 1ns / 1ps

module mtmkr_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/mtmkr_ctrl.sv]
`timescale 1ns / 1ps

module mtmkr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  mtmkr_pkg::sts_t    sts,
  output mtmkr_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_code = mtmkr_pkg::RES_UNMAPPED;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.req_write) begin
            cmd.res_code = mtmkr_pkg::RES_WRITTEN;
            state_nxt    = ST_DONE;
          end else if (sts.is_mod) begin
            cmd.res_code = mtmkr_pkg::RES_CONSUMED;
            cmd.mod_edge = 1'b1;
            state_nxt    = ST_DONE;
          end else if (sts.lookup_en) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = ST_DONE;
        end else if (sts.miss) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/mtmkr_dp.sv]
`timescale 1ns / 1ps

module mtmkr_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mtmkr_pkg::cmd_t                        cmd,
  output mtmkr_pkg::sts_t                        sts,
  input  logic                                   in_tuser,
  input  logic [mtmkr_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                   cfg_valid,
  input  logic [mtmkr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mtmkr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                   out_tready,
  output logic                                   out_tvalid,
  output logic [mtmkr_pkg::RES_BITS-1:0]         out_tuser,
  output logic [mtmkr_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int KB = mtmkr_pkg::KEY_BITS;
  localparam int TB = mtmkr_pkg::TIME_BITS;
  localparam int AW = mtmkr_pkg::ADDR_W;
  localparam int CW = mtmkr_pkg::CNT_W;

  logic [KB-1:0]                      in_scan;
  logic [KB-1:0]                      in_key;
  logic                               in_press;
  logic [TB-1:0]                      in_time;
  logic [mtmkr_pkg::SLOT_BITS-1:0]    in_slot;
  logic [KB-1:0]                      in_target;
  logic                               in_shift;
  logic [mtmkr_pkg::SLOT_EXT_W-1:0]   slot_ext;

  logic [KB-1:0]                      modifier_r;
  logic [TB-1:0]                      tap_gap_r;
  logic [mtmkr_pkg::TAP_BITS-1:0]     tap_r;
  logic [mtmkr_pkg::TAP_BITS-1:0]     tap_nxt;
  logic [TB-1:0]                      last_r;
  logic [TB-1:0]                      last_nxt;
  logic [TB-1:0]                      gap;

  logic [mtmkr_pkg::VALID_N-1:0]      valid_r;
  logic [mtmkr_pkg::VALID_N-1:0]      valid_nxt;
  logic                               wr_en;
  logic [AW-1:0]                      wr_addr;
  mtmkr_pkg::entry_t                  wr_entry;
  mtmkr_pkg::entry_t                  rd_entry;

  logic [KB-1:0]                      key_r;
  logic [CW-1:0]                      cnt_r;
  logic [CW-1:0]                      cnt_nxt;
  logic                               issue;
  logic                               chk_vld_r;
  logic [AW-1:0]                      chk_idx_r;

  logic [mtmkr_pkg::RES_BITS-1:0]     res_code_r;
  logic [mtmkr_pkg::RES_BITS-1:0]     res_code_nxt;
  logic [KB-1:0]                      res_key_r;
  logic [KB-1:0]                      res_key_nxt;
  logic                               res_shift_r;
  logic                               res_shift_nxt;

  logic                               out_valid_r;
  logic [mtmkr_pkg::RES_BITS-1:0]     out_code_r;
  logic [KB-1:0]                      out_key_r;
  logic                               out_shift_r;
  logic [mtmkr_pkg::TAP_BITS-1:0]     out_tap_r;

  assign in_scan   = in_tdata[mtmkr_pkg::OFS_SCAN   +: KB];
  assign in_key    = in_tdata[mtmkr_pkg::OFS_KEY    +: KB];
  assign in_press  = in_tdata[mtmkr_pkg::OFS_PRESS];
  assign in_time   = in_tdata[mtmkr_pkg::OFS_TIME   +: TB];
  assign in_slot   = in_tdata[mtmkr_pkg::OFS_SLOT   +: mtmkr_pkg::SLOT_BITS];
  assign in_target = in_tdata[mtmkr_pkg::OFS_TARGET +: KB];
  assign in_shift  = in_tdata[mtmkr_pkg::OFS_SHIFT];
  assign slot_ext  = mtmkr_pkg::SLOT_EXT_W'(in_slot);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modifier_r <= mtmkr_pkg::MODIFIER_RESET;
      tap_gap_r  <= mtmkr_pkg::TAP_GAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mtmkr_pkg::CFG_MODIFIER: modifier_r <= cfg_data[KB-1:0];
        mtmkr_pkg::CFG_TAP_GAP:  tap_gap_r  <= cfg_data[TB-1:0];
        default: ;
      endcase
    end
  end

  // tap tracking
  assign gap = in_time - last_r;

  always_comb begin
    tap_nxt  = tap_r;
    last_nxt = last_r;
    if (cmd.mod_edge) begin
      if (!in_press) begin
        last_nxt = in_time;
        unique case (tap_r)
          mtmkr_pkg::TAP_HELD:        tap_nxt = mtmkr_pkg::TAP_SINGLE;
          mtmkr_pkg::TAP_HELD_CLICK:  tap_nxt = mtmkr_pkg::TAP_DOUBLE;
          mtmkr_pkg::TAP_HELD_DOUBLE: tap_nxt = mtmkr_pkg::TAP_IDLE;
          default:                    tap_nxt = tap_r;
        endcase
      end else if (tap_r == mtmkr_pkg::TAP_DOUBLE) begin
        tap_nxt = mtmkr_pkg::TAP_HELD_DOUBLE;
      end else begin
        last_nxt = in_time;
        unique case (tap_r)
          mtmkr_pkg::TAP_IDLE:   tap_nxt = mtmkr_pkg::TAP_HELD;
          mtmkr_pkg::TAP_SINGLE: tap_nxt = (gap <= tap_gap_r) ? mtmkr_pkg::TAP_HELD_CLICK
                                                                : mtmkr_pkg::TAP_HELD;
          default:               tap_nxt = tap_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r  <= mtmkr_pkg::TAP_IDLE;
      last_r <= '0;
    end else begin
      tap_r  <= tap_nxt;
      last_r <= last_nxt;
    end
  end

  // remap table
  assign wr_en           = cmd.accept && in_tuser &&
                           (slot_ext < mtmkr_pkg::SLOT_EXT_W'(mtmkr_pkg::TABLE_DEPTH));
  assign wr_addr         = slot_ext[AW-1:0];
  assign wr_entry.source = in_key;
  assign wr_entry.target = in_target;
  assign wr_entry.shift  = in_shift;

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  mtmkr_ram #(
    .WIDTH ($bits(mtmkr_pkg::entry_t)),
    .DEPTH (mtmkr_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (cnt_r[AW-1:0]),
    .rdata (rd_entry)
  );

  // lookup scan: one read issued per cycle, checked against the registered read data
  assign issue = cmd.scan_run && (cnt_r < CW'(mtmkr_pkg::TABLE_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.accept) begin
      cnt_nxt = '0;
    end else if (issue) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      chk_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= cnt_r[AW-1:0];
    if (cmd.accept) begin
      key_r <= in_key;
    end
  end

  assign sts.req_write = in_tuser;
  assign sts.is_mod    = (in_scan == modifier_r);
  assign sts.lookup_en = (tap_r != mtmkr_pkg::TAP_IDLE) && (tap_r != mtmkr_pkg::TAP_SINGLE);
  assign sts.hit       = chk_vld_r && valid_r[chk_idx_r] && (rd_entry.source == key_r);
  assign sts.miss      = !chk_vld_r && (cnt_r == CW'(mtmkr_pkg::TABLE_DEPTH));
  assign sts.out_free  = !out_valid_r || out_tready;

  // result
  always_comb begin
    res_code_nxt  = res_code_r;
    res_key_nxt   = res_key_r;
    res_shift_nxt = res_shift_r;
    if (cmd.accept) begin
      res_code_nxt  = cmd.res_code;
      res_key_nxt   = in_key;
      res_shift_nxt = 1'b0;
    end else if (cmd.take_hit) begin
      res_code_nxt  = mtmkr_pkg::RES_MAPPED;
      res_key_nxt   = rd_entry.target;
      res_shift_nxt = rd_entry.shift;
    end
  end

  always_ff @(posedge clk) begin
    res_code_r  <= res_code_nxt;
    res_key_r   <= res_key_nxt;
    res_shift_r <= res_shift_nxt;
    if (cmd.out_load) begin
      out_code_r  <= res_code_r;
      out_key_r   <= res_key_r;
      out_shift_r <= res_shift_r;
      out_tap_r   <= tap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_code_r;
  assign out_tdata  = mtmkr_pkg::OUT_TDATA_W'({out_tap_r, out_shift_r, out_key_r});

endmodule

[hw/rtl/multi_tap_modifier_key_remapper_unit.sv]
`timescale 1ns / 1ps

// Multi-tap modifier key remapper.
// in_*  : one beat per request. in_tuser = 0 key event, 1 remap table write.
// out_* : exactly one result beat per request. out_tuser is the result code
//         (consumed, unmapped, mapped, table written).
// cfg_* : register writes (0 modifier scan code, 1 double-tap gap in us),
//         always ready; write only while no request is in flight.
// Table writes, modifier events and keys arriving while the modifier is not
// held or latched pass from accept through the done state to the output
// register. A lookup walks the 32-slot table through the single read port of
// the slot RAM, one slot a cycle, until a slot matches or all slots miss.
// One request is handled at a time; the next is taken once the previous
// result sits in the output register.
// Reset: tap state idle, all slots invalid, registers at 57 and 1000000;
// no clearing pass is needed.
// A stalled out_tready holds the result beat; one further request may be
// taken and worked on, then in_tready stays low until the beat is taken.

module multi_tap_modifier_key_remapper_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                in_tuser,  // req_type
  // scan_code, key_code, pressed, time_us, entry_index, target_code, needs_shift
  input  logic [mtmkr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mtmkr_pkg::RES_BITS-1:0]      out_tuser, // result_code
  // mapped_key, shift_needed, tap_status
  output logic [mtmkr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mtmkr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mtmkr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  mtmkr_pkg::cmd_t cmd;
  mtmkr_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  mtmkr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtmkr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while previous one still in flight");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten before its beat was taken");

  a_mod_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_edge |-> (cmd.accept && !in_tuser))
    else $error("tap state moved outside a modifier event");

  a_mapped_needs_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == mtmkr_pkg::RES_MAPPED)) |->
      ((out_tdata[mtmkr_pkg::OFS_OTAP +: mtmkr_pkg::TAP_BITS] != mtmkr_pkg::TAP_IDLE) &&
       (out_tdata[mtmkr_pkg::OFS_OTAP +: mtmkr_pkg::TAP_BITS] != mtmkr_pkg::TAP_SINGLE)))
    else $error("key remapped while modifier neither held nor latched");

endmodule
